// ----- hdl/lctf_pkg.sv -----
// ----------------------------------------------------------------------------
// Log chunk text filter package
// Shared constants, types and helpers for the text chunk filter.
// ----------------------------------------------------------------------------
package lctf_pkg;

    localparam int MAX_PAYLOAD_DEF = 4096;
    localparam int SINK_BYTES_DEF  = 32768;

    localparam logic [7:0]  KEY_RESET = 8'd2;
    localparam logic [15:0] CAP_RESET = 16'h8000;

    typedef enum logic [0:0] {
        CFG_TEXT_KEY = 1'b0,
        CFG_SINK_CAP = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_CONT = 2'd0,
        PH_KEY  = 2'd1,
        PH_SIZE = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    // segment write request from the parser to the sink accounting
    typedef struct packed {
        logic        wr;
        logic [31:0] len;
    } seg_req_t;

endpackage

// ----- hdl/log_chunk_text_filter.sv -----
// ----------------------------------------------------------------------------
// Log chunk text filter
// Passes text-log chunk bytes of a log packet stream and accounts sink room.
// ----------------------------------------------------------------------------
// One item a cycle: each item is registered at the input, handled by the
// parser and sink accounting once the output register can take a result,
// and its result (an accepted byte or a read answer) lands in an output
// register; an item that yields no result leaves nothing behind. Input ready
// drops only while the input register holds an item and the output register
// holds a result that the sink side has not taken.
module log_chunk_text_filter import lctf_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int SINK_BYTES  = SINK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    input  logic [12:0] s_payload_len,
    input  logic [63:0] s_process_id,
    input  logic [63:0] s_thread_id,
    input  logic        s_is_head,
    input  logic        s_is_tail,
    input  logic [15:0] s_reader_limit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic [15:0] m_xfer_size,
    output logic [31:0] m_drop_count,
    output logic        m_read_done
);
    logic [7:0]  key_reg;
    logic [15:0] cap_reg;

    // input register
    logic        iv_reg;
    logic        rq_reg, fb_reg, lb_reg, hd_reg, tl_reg;
    logic [7:0]  b_reg;
    logic [12:0] pl_reg;
    logic [63:0] pid_reg, tid_reg;
    logic [15:0] lim_reg;

    logic        stall;
    seg_req_t    seg;
    logic        seg_ok, emit;
    logic [15:0] rd_size;
    logic [31:0] rd_drops;

    // output register must be free before the staged item can finish
    assign stall     = m_valid && !m_ready;
    assign s_ready   = !(iv_reg && stall);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= KEY_RESET;
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TEXT_KEY: key_reg <= cfg_data[7:0];
                CFG_SINK_CAP: cap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic go;
    assign go = iv_reg && !stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) iv_reg <= 1'b0;
        else if (s_ready) iv_reg <= s_valid;
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            rq_reg <= s_req_type; b_reg <= s_data_byte; fb_reg <= s_first_byte;
            lb_reg <= s_last_byte; pl_reg <= s_payload_len; pid_reg <= s_process_id;
            tid_reg <= s_thread_id; hd_reg <= s_is_head; tl_reg <= s_is_tail;
            lim_reg <= s_reader_limit;
        end
    end

    lctf_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
        .aclk, .aresetn, .en(go && !rq_reg), .key_cfg(key_reg), .b(b_reg),
        .first(fb_reg), .last(lb_reg), .plen_in(pl_reg), .pid(pid_reg), .tid(tid_reg),
        .head(hd_reg), .tail(tl_reg), .seg, .seg_ok, .emit
    );

    seg_req_t seg_g;
    always_comb begin
        seg_g = seg;
        seg_g.wr = seg.wr && go && !rq_reg;
    end

    lctf_sink #(.SINK_BYTES(SINK_BYTES)) u_sink (
        .aclk, .aresetn, .cap_cfg(cap_reg), .seg(seg_g), .seg_ok,
        .rd(go && rq_reg), .rd_limit(lim_reg), .rd_size, .rd_drops
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid <= 1'b0;
        else if (!stall) m_valid <= go && (rq_reg || emit);
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            m_out_byte   <= rq_reg ? 8'd0 : b_reg;
            m_byte_valid <= !rq_reg;
            m_xfer_size  <= rq_reg ? rd_size : 16'd0;
            m_drop_count <= rq_reg ? rd_drops : 32'd0;
            m_read_done  <= rq_reg;
        end
    end
endmodule

// ----- hdl/lctf_sink.sv -----
// ----------------------------------------------------------------------------
// Sink accounting
// Fill level and drop counter; segment admit decision and read-and-clear.
// ----------------------------------------------------------------------------
module lctf_sink import lctf_pkg::*; #(
    parameter int SINK_BYTES = SINK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] cap_cfg,
    input  seg_req_t    seg,
    output logic        seg_ok,
    input  logic        rd,
    input  logic [15:0] rd_limit,
    output logic [15:0] rd_size,
    output logic [31:0] rd_drops
);
    localparam logic [16:0] SINK_MAX = 17'(SINK_BYTES);

    logic [15:0] fill_reg, fill_next;
    logic [31:0] drops_reg, drops_next;
    logic [16:0] cap;
    logic [16:0] room;
    logic        drop;

    always_comb begin
        cap  = ({1'b0, cap_cfg} < SINK_MAX) ? {1'b0, cap_cfg} : SINK_MAX;
        room = (cap > {1'b0, fill_reg}) ? cap - {1'b0, fill_reg} : 17'd0;
        seg_ok = (seg.len == 32'd0) || (seg.len <= {15'd0, room});
        drop = 1'b0;
        fill_next = fill_reg;
        rd_size = fill_reg;
        if (rd) begin
            if (fill_reg > rd_limit) begin
                rd_size = rd_limit;
                drop = 1'b1;
            end
            fill_next = '0;
        end else if (seg.wr && seg.len != 32'd0) begin
            if (seg_ok) fill_next = fill_reg + seg.len[15:0];
            else drop = 1'b1;
        end
        rd_drops = (drop && drops_reg != '1) ? drops_reg + 32'd1 : drops_reg;
        drops_next = rd ? 32'd0 : rd_drops;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            drops_reg <= '0;
        end else begin
            fill_reg  <= fill_next;
            drops_reg <= drops_next;
        end
    end
endmodule

// ----- hdl/lctf_parser.sv -----
// ----------------------------------------------------------------------------
// Chunk parser
// Packet tracking, carry-over and ULEB128 chunk header decode, one byte a cycle while enabled.
// ----------------------------------------------------------------------------
module lctf_parser import lctf_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [7:0]  key_cfg,
    input  logic [7:0]  b,
    input  logic        first,
    input  logic        last,
    input  logic [12:0] plen_in,
    input  logic [63:0] pid,
    input  logic [63:0] tid,
    input  logic        head,
    input  logic        tail,
    output seg_req_t    seg,
    input  logic        seg_ok,
    output logic        emit
);
    localparam logic [12:0] MAXP = 13'(MAX_PAYLOAD > 8191 ? 8191 : MAX_PAYLOAD);

    phase_t      ph_reg, ph_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  sh_reg, sh_next;
    logic        txt_reg, txt_next;
    logic [31:0] left_reg, left_next;
    logic [12:0] pos_reg, pos_next;
    logic        sacc_reg, sacc_next;
    logic        pdrop_reg, pdrop_next;
    logic [63:0] lp_reg, lp_next, lt_reg, lt_next;
    logic [31:0] cl_reg, cl_next;
    logic        ct_reg, ct_next;

    logic [12:0] plen;
    logic [31:0] uval, rem, seglen;

    always_comb begin
        plen = ({3'd0, plen_in} > {3'd0, MAXP}) ? MAXP : plen_in;
        ph_next = ph_reg; acc_next = acc_reg; sh_next = sh_reg; txt_next = txt_reg;
        left_next = left_reg; pos_next = pos_reg; sacc_next = sacc_reg;
        pdrop_next = pdrop_reg; lp_next = lp_reg; lt_next = lt_reg;
        cl_next = cl_reg; ct_next = ct_reg;
        seg = '0; emit = 1'b0;
        uval = '0; rem = '0; seglen = '0;
        if (en) begin
            if (first) begin
                pos_next = '0; acc_next = '0; sh_next = '0;
                pdrop_next = (pid != lp_reg || tid != lt_reg) && !head;
                if (!pdrop_next) begin
                    if (tid == lt_reg && cl_reg != 0) begin
                        ph_next = PH_CONT;
                        seg.wr = ct_reg;
                        seg.len = ({19'd0, plen} < cl_reg) ? {19'd0, plen} : cl_reg;
                        sacc_next = ct_reg && seg_ok;
                    end else ph_next = PH_KEY;
                end
            end
            if (!pdrop_next && pos_next < plen) begin
                if (ph_next == PH_CONT && cl_next == 0) begin
                    ph_next = PH_KEY; acc_next = '0; sh_next = '0;
                end
                case (ph_next)
                    PH_CONT: begin
                        emit = sacc_next;
                        cl_next = cl_next - 32'd1;
                        if (cl_next == 0) begin
                            ph_next = PH_KEY; acc_next = '0; sh_next = '0;
                        end
                    end
                    PH_KEY, PH_SIZE: begin
                        uval = acc_next;
                        if (sh_next < 6'd32) uval = acc_next | ({25'd0, b[6:0]} << sh_next);
                        acc_next = uval;
                        if (sh_next < 6'd35) sh_next = sh_next + 6'd7;
                        if (!b[7]) begin
                            if (ph_next == PH_KEY) begin
                                txt_next = (uval == {24'd0, key_cfg});
                                ph_next = PH_SIZE;
                            end else begin
                                rem = ({19'd0, plen} > {19'd0, pos_next} + 32'd1)
                                    ? {19'd0, plen} - {19'd0, pos_next} - 32'd1 : 32'd0;
                                seglen = (uval < rem) ? uval : rem;
                                seg.wr = txt_next;
                                seg.len = seglen;
                                sacc_next = txt_next && seg_ok;
                                left_next = uval;
                                ph_next = (uval != 0) ? PH_DATA : PH_KEY;
                            end
                            acc_next = '0; sh_next = '0;
                        end
                    end
                    default: begin
                        emit = txt_next && sacc_next;
                        left_next = left_next - 32'd1;
                        if (left_next == 0) begin
                            ph_next = PH_KEY; acc_next = '0; sh_next = '0;
                        end
                    end
                endcase
                if (pos_next != 13'h1FFF) pos_next = pos_next + 13'd1;
            end
            if (last && !pdrop_next && !tail) begin
                lp_next = pid; lt_next = tid;
                if (ph_next == PH_DATA) begin
                    cl_next = left_next; ct_next = txt_next;
                end else if (ph_next != PH_CONT) begin
                    cl_next = '0; ct_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_CONT; acc_reg <= '0; sh_reg <= '0; txt_reg <= 1'b0;
            left_reg <= '0; pos_reg <= '0; sacc_reg <= 1'b0; pdrop_reg <= 1'b0;
            lp_reg <= '0; lt_reg <= '0; cl_reg <= '0; ct_reg <= 1'b0;
        end else begin
            ph_reg <= ph_next; acc_reg <= acc_next; sh_reg <= sh_next; txt_reg <= txt_next;
            left_reg <= left_next; pos_reg <= pos_next; sacc_reg <= sacc_next;
            pdrop_reg <= pdrop_next; lp_reg <= lp_next; lt_reg <= lt_next;
            cl_reg <= cl_next; ct_reg <= ct_next;
        end
    end
endmodule

// ----- hdl/lctf_checker.sv -----
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module lctf_checker import lctf_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_byte_valid,
    input logic [15:0] m_xfer_size,
    input logic [31:0] m_drop_count,
    input logic        m_read_done
);
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input item withdrawn before accept");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_read_done))
        else $error("result changed while stalled");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_valid != m_read_done))
        else $error("result is neither byte nor read answer");
    a_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_xfer_size == 16'd0 && m_drop_count == 32'd0)
        else $error("byte result carries read fields");
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_done |-> m_xfer_size <= 16'h8000 && m_out_byte == 8'd0)
        else $error("read size out of range");
endmodule

bind log_chunk_text_filter lctf_checker u_lctf_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_out_byte,
    .m_byte_valid, .m_xfer_size, .m_drop_count, .m_read_done
);

// ----- tb/log_chunk_text_filter_tb.sv -----
// ----------------------------------------------------------------------------
// Log chunk text filter testbench
// Streams log packets built from ULEB128-framed chunks, plus noise packets and
// read-and-clear requests, through the filter under random bursts and output
// stalls; an in-bench predictor tracks parser and sink state and every
// result is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module log_chunk_text_filter_tb;
    import lctf_pkg::*;

    typedef struct {
        logic        req_type;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [12:0] payload_len;
        logic [63:0] process_id;
        logic [63:0] thread_id;
        logic        is_head;
        logic        is_tail;
        logic [15:0] reader_limit;
    } log_item_t;

    typedef struct {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [15:0] xfer_size;
        logic [31:0] drop_count;
        logic        read_done;
    } filt_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = 1'b0;
    logic [7:0]  s_data_byte = '0;
    logic        s_first_byte = 1'b0;
    logic        s_last_byte = 1'b0;
    logic [12:0] s_payload_len = '0;
    logic [63:0] s_process_id = '0;
    logic [63:0] s_thread_id = '0;
    logic        s_is_head = 1'b0;
    logic        s_is_tail = 1'b0;
    logic [15:0] s_reader_limit = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic [15:0] m_xfer_size;
    logic [31:0] m_drop_count;
    logic        m_read_done;

    log_chunk_text_filter dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------- predictor state ----------------
    logic [7:0]  key_reg = KEY_RESET;
    logic [15:0] cap_reg = CAP_RESET;
    phase_t      phase = PH_CONT;
    logic [31:0] uleb_val = '0;
    int          uleb_sh = 0;
    logic        chunk_text = 1'b0;
    logic [31:0] chunk_left = '0;
    int          pos = 0;
    logic        seg_ok = 1'b0;
    logic        pkt_drop = 1'b0;
    logic [63:0] last_pid = '0;
    logic [63:0] last_tid = '0;
    logic [31:0] carry_left = '0;
    logic        carry_text = 1'b0;
    logic [31:0] fill = '0;
    logic [31:0] drops = '0;

    filt_result_t expected_q[$];
    log_item_t    pending_q[$];
    log_item_t    cur_item;

    int errors = 0;
    int n_items = 0;
    int n_bytes = 0;
    int n_reads = 0;
    int n_drops_seen = 0;
    bit cfg_busy = 0;

    function automatic void bump_drops();
        if (drops != 32'hFFFF_FFFF) drops++;
    endfunction

    function automatic bit sink_write(logic [31:0] len);
        logic [31:0] cap;
        logic [31:0] room;
        cap = (cap_reg < SINK_BYTES_DEF) ? cap_reg : SINK_BYTES_DEF;
        room = (cap > fill) ? cap - fill : 0;
        if (len == 0) return 1'b1;
        if (len > room) begin
            bump_drops();
            return 1'b0;
        end
        fill = (fill + len) & 32'hFFFF;
        return 1'b1;
    endfunction

    function automatic bit parse_byte(logic [7:0] b, int plen);
        bit emit;
        logic [31:0] size;
        logic [31:0] left;
        logic [31:0] seg;
        emit = 0;
        if (phase == PH_CONT && carry_left == 0) begin
            phase = PH_KEY;
            uleb_val = 0;
            uleb_sh = 0;
        end
        case (phase)
            PH_CONT: begin
                emit = seg_ok;
                carry_left--;
                if (carry_left == 0) begin
                    phase = PH_KEY;
                    uleb_val = 0;
                    uleb_sh = 0;
                end
            end
            PH_KEY, PH_SIZE: begin
                if (uleb_sh < 32) uleb_val |= {25'd0, b[6:0]} << uleb_sh;
                if (uleb_sh < 35) uleb_sh += 7;
                if (!b[7]) begin
                    if (phase == PH_KEY) begin
                        chunk_text = (uleb_val == {24'd0, key_reg});
                        phase = PH_SIZE;
                    end else begin
                        size = uleb_val;
                        left = (plen > pos + 1) ? plen - pos - 1 : 0;
                        seg = (size < left) ? size : left;
                        seg_ok = chunk_text ? sink_write(seg) : 1'b0;
                        chunk_left = size;
                        phase = (size != 0) ? PH_DATA : PH_KEY;
                    end
                    uleb_val = 0;
                    uleb_sh = 0;
                end
            end
            default: begin
                emit = chunk_text && seg_ok;
                chunk_left--;
                if (chunk_left == 0) begin
                    phase = PH_KEY;
                    uleb_val = 0;
                    uleb_sh = 0;
                end
            end
        endcase
        return emit;
    endfunction

    function automatic void predict_filter(log_item_t it);
        filt_result_t r;
        int plen;
        logic [31:0] seg;
        bit emit;
        emit = 0;
        if (it.req_type) begin
            r.out_byte = 0;
            r.byte_valid = 0;
            r.xfer_size = fill[15:0];
            if (fill > {16'd0, it.reader_limit}) begin
                r.xfer_size = it.reader_limit;
                bump_drops();
            end
            r.drop_count = drops;
            r.read_done = 1;
            expected_q.push_back(r);
            fill = 0;
            drops = 0;
            return;
        end
        plen = (it.payload_len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : it.payload_len;
        if (it.first_byte) begin
            pos = 0;
            uleb_val = 0;
            uleb_sh = 0;
            pkt_drop = ((it.process_id != last_pid) || (it.thread_id != last_tid))
                       && !it.is_head;
            if (!pkt_drop) begin
                if (it.thread_id == last_tid && carry_left > 0) begin
                    seg = (plen < carry_left) ? plen : carry_left;
                    phase = PH_CONT;
                    seg_ok = carry_text ? sink_write(seg) : 1'b0;
                end else begin
                    phase = PH_KEY;
                end
            end
        end
        if (!pkt_drop && pos < plen) begin
            emit = parse_byte(it.data_byte, plen);
            if (pos < 13'h1FFF) pos++;
        end
        // tail packets leave ids and carry alone (carry may have shrunk)
        if (it.last_byte && !pkt_drop && !it.is_tail) begin
            last_pid = it.process_id;
            last_tid = it.thread_id;
            if (phase == PH_DATA) begin
                carry_left = chunk_left;
                carry_text = chunk_text;
            end else if (phase != PH_CONT) begin
                carry_left = 0;
                carry_text = 0;
            end
        end
        if (emit) begin
            r.out_byte = it.data_byte;
            r.byte_valid = 1;
            r.xfer_size = 0;
            r.drop_count = 0;
            r.read_done = 0;
            expected_q.push_back(r);
        end
    endfunction

    // ---------------- driver ----------------
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;

    always @(posedge aclk) begin
        bit fire;
        fire = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (fire) predict_filter(cur_item);
            if (!s_valid || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    cur_item = pending_q.pop_front();
                    s_req_type     <= cur_item.req_type;
                    s_data_byte    <= cur_item.data_byte;
                    s_first_byte   <= cur_item.first_byte;
                    s_last_byte    <= cur_item.last_byte;
                    s_payload_len  <= cur_item.payload_len;
                    s_process_id   <= cur_item.process_id;
                    s_thread_id    <= cur_item.thread_id;
                    s_is_head      <= cur_item.is_head;
                    s_is_tail      <= cur_item.is_tail;
                    s_reader_limit <= cur_item.reader_limit;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor, config apply, watchdog ----------------
    int stall_mode = 0;
    int stall_cnt = 0;

    always @(posedge aclk) begin
        filt_result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TEXT_KEY) key_reg = cfg_data[7:0];
                else cap_reg = cfg_data;
                cfg_valid <= 1'b0;
                cfg_busy = 0;
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: byte %0h read_done %0b", m_out_byte, m_read_done);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_out_byte !== e.out_byte) begin
                        $error("out_byte exp %0h got %0h", e.out_byte, m_out_byte); errors++;
                    end
                    if (m_byte_valid !== e.byte_valid) begin
                        $error("byte_valid exp %0b got %0b", e.byte_valid, m_byte_valid);
                        errors++;
                    end
                    if (m_xfer_size !== e.xfer_size) begin
                        $error("xfer_size exp %0d got %0d", e.xfer_size, m_xfer_size);
                        errors++;
                    end
                    if (m_drop_count !== e.drop_count) begin
                        $error("drop_count exp %0d got %0d", e.drop_count, m_drop_count);
                        errors++;
                    end
                    if (m_read_done !== e.read_done) begin
                        $error("read_done exp %0b got %0b", e.read_done, m_read_done);
                        errors++;
                    end
                    if (e.read_done) begin
                        n_reads++;
                        if (e.drop_count != 0) n_drops_seen++;
                    end else begin
                        n_bytes++;
                    end
                end
            end
            // receiver stall pattern: always ready, random, or mostly stalled
            stall_cnt++;
            if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 20000) begin
                $display("timeout: no progress for %0d cycles", idle_cycles);
                $display("log_chunk_text_filter_tb: errors");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    logic [7:0] msg_q[$];
    logic [7:0] gen_key;

    function automatic void add_item(log_item_t it);
        pending_q.push_back(it);
        n_items++;
    endfunction

    function automatic void add_read(logic [15:0] lim);
        log_item_t it;
        it = '{default: '0};
        it.req_type = 1;
        it.data_byte = $urandom;
        it.reader_limit = lim;
        add_item(it);
    endfunction

    function automatic logic [15:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic void push_uleb(logic [63:0] v, int pad);
        logic [7:0] b;
        forever begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0) msg_q.push_back(b | 8'h80);
            else if (pad > 0) begin
                msg_q.push_back(b | 8'h80);
                pad--;
            end else begin
                msg_q.push_back(b);
                break;
            end
        end
    endfunction

    // one packet; mode 0 exact length, 1 short length, 2 oversized length
    function automatic void add_packet(logic [63:0] pid, logic [63:0] tid,
                                       bit head, bit tail, int lo, int n, int mode);
        log_item_t it;
        int i;
        it = '{default: '0};
        it.process_id = pid;
        it.thread_id = tid;
        it.is_head = head;
        it.is_tail = tail;
        it.reader_limit = $urandom;
        case (mode)
            1: it.payload_len = (n > 1) ? $urandom_range(0, n - 1) : 0;
            2: it.payload_len = ($urandom_range(0, 1) == 0) ? 13'h1FFF : 13'd4097;
            default: it.payload_len = n;
        endcase
        if (n == 0) begin
            it.first_byte = 1;
            it.last_byte = 1;
            it.data_byte = $urandom;
            add_item(it);
            return;
        end
        for (i = 0; i < n; i++) begin
            it.data_byte = msg_q[lo + i];
            it.first_byte = (i == 0);
            it.last_byte = (i == n - 1);
            add_item(it);
        end
    endfunction

    function automatic void add_message(logic [63:0] pid, logic [63:0] tid);
        int nch;
        int k;
        int j;
        int sz;
        int idx;
        int n;
        int mode;
        logic [63:0] key;
        msg_q.delete();
        nch = $urandom_range(1, 4);
        for (k = 0; k < nch; k++) begin
            case ($urandom_range(0, 9))
                0: key = $urandom;
                1: key = {$urandom, 24'd0, gen_key};   // bits above 32 are lost
                2: key = 200;
                default: key = gen_key;
            endcase
            push_uleb(key, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0);
            sz = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 14);
            if ($urandom_range(0, 15) == 0) sz = $urandom_range(130, 160);
            push_uleb(sz, ($urandom_range(0, 9) == 0) ? 1 : 0);
            for (j = 0; j < sz; j++) msg_q.push_back($urandom);
        end
        idx = 0;
        while (idx < msg_q.size()) begin
            n = $urandom_range(1, 12);
            if (n > msg_q.size() - idx) n = msg_q.size() - idx;
            mode = $urandom_range(0, 19);
            mode = (mode == 0) ? 1 : (mode == 1) ? 2 : 0;
            add_packet(pid, tid, idx == 0, idx + n == msg_q.size(), idx, n, mode);
            idx += n;
            if ($urandom_range(0, 19) == 0) add_read(rand_limit());
            if ($urandom_range(0, 29) == 0) add_packet(pid, tid, 0, 0, 0, 0, 0);
        end
    endfunction

    function automatic void add_noise();
        log_item_t it;
        it.req_type = 0;
        it.data_byte = $urandom;
        it.first_byte = $urandom;
        it.last_byte = $urandom;
        it.payload_len = $urandom;
        it.process_id = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : $urandom_range(1, 2);
        it.thread_id = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom} : $urandom_range(10, 12);
        it.is_head = $urandom;
        it.is_tail = $urandom;
        it.reader_limit = $urandom;
        add_item(it);
    endfunction

    task automatic wait_idle();
        while (pending_q.size() != 0 || s_valid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [15:0] val);
        wait_idle();
        cfg_busy = 1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        while (cfg_busy) @(posedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        logic [7:0]  keys[6];
        logic [15:0] caps[6];
        int ph;
        int target;
        int sel;
        logic [63:0] pid;
        logic [63:0] tid;
        keys = '{8'd2, 8'd0, 8'd255, 8'd7, 8'd128, 8'd2};
        caps = '{16'h8000, 16'd30, 16'd0, 16'hFFFF, 16'd12, 16'd60};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: read on empty sink, one clean text message, edge lengths
        gen_key = KEY_RESET;
        add_read(16'd0);
        msg_q = '{8'h02, 8'h03, 8'hAA, 8'h55, 8'hFF};
        add_packet(64'd1, 64'd10, 1, 0, 0, 5, 0);
        msg_q = '{8'h82, 8'h80, 8'h00, 8'h02, 8'h00, 8'h01};
        add_packet(64'd1, 64'd10, 1, 1, 0, 6, 2);
        msg_q = '{8'h02, 8'h04, 8'h11};
        add_packet(64'd1, 64'd10, 1, 0, 0, 3, 0);
        msg_q = '{8'h22, 8'h33, 8'h44};
        add_packet(64'd1, 64'd10, 0, 0, 0, 3, 0);   // carry fills middle packet
        add_packet(64'd2, 64'd11, 0, 0, 0, 3, 0);   // foreign non-head: dropped
        add_read(16'd1);
        add_read(16'hFFFF);
        wait_idle();

        for (ph = 0; ph < 6; ph++) begin
            cfg_write(CFG_TEXT_KEY, (ph == 5) ? $urandom_range(0, 255) : keys[ph]);
            cfg_write(CFG_SINK_CAP, (ph == 5) ? $urandom_range(0, 100) : caps[ph]);
            gen_key = key_reg;
            target = n_items + 220;
            while (n_items < target) begin
                sel = $urandom_range(0, 19);
                pid = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : $urandom_range(1, 2);
                tid = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : $urandom_range(10, 12);
                if (sel < 15) add_message(pid, tid);
                else if (sel < 18) add_noise();
                else add_read(rand_limit());
            end
            add_read(rand_limit());
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        $display("covered %0d items over 6 key/capacity settings: %0d text bytes, %0d reads",
                 n_items, n_bytes, n_reads);
        $display("%0d read answers carried a nonzero drop count", n_drops_seen);
        if (errors == 0) $display("log_chunk_text_filter_tb: clean");
        else $display("log_chunk_text_filter_tb: errors");
        $finish;
    end

endmodule
